FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the TGA decoder RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define TGA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion checked in and out of reset.
`define TGA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/tga_pkg.sv
// Package for the TGA RLE image decoder: parser phases, result kinds,
// header byte offsets, format codes and the structs passed between modules.
`timescale 1ns / 1ps

package tga_pkg;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_IDSKIP = 3'd1,
    PH_PKTHDR = 3'd2,
    PH_PIXEL  = 3'd3,
    PH_IDLE   = 3'd4
  } tga_phase_e;

  typedef enum logic [1:0] {
    KIND_SEG      = 2'd0,
    KIND_HDR      = 2'd1,
    KIND_BAD_TYPE = 2'd2,
    KIND_BAD_FMT  = 2'd3
  } tga_kind_e;

  // Header byte offsets
  localparam logic [4:0] HDR_ID_LEN    = 5'd0;
  localparam logic [4:0] HDR_CMAP_TYPE = 5'd1;
  localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;
  localparam logic [4:0] HDR_DESC      = 5'd17;

  localparam logic [7:0] TYPE_RAW     = 8'd2;
  localparam logic [7:0] TYPE_RLE     = 8'd10;
  localparam logic [7:0] DEPTH_24     = 8'd24;
  localparam logic [7:0] DEPTH_32     = 8'd32;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [6:0] PKT_LEN_MASK = 7'h7f;
  localparam int unsigned PKT_RUN_BIT = 7;

  // Row/column divider: quotient is at most 128, two bits per cycle
  localparam int unsigned DIM_W      = 16;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned TOTAL_W    = DIM_W + 1;
  localparam int unsigned QUOT_W     = 8;
  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned DIV_CYCLES = QUOT_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);
  localparam int unsigned DSR_W      = DIM_W + QUOT_W - 1;
  localparam int unsigned AREA_W     = 2 * DIM_W;

  typedef struct packed {
    tga_kind_e          kind;
    logic [DIM_W-1:0]   seg_row;
    logic [DIM_W-1:0]   seg_column;
    logic [CNT_W-1:0]   seg_count;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic               has_alpha;
    logic               image_done;
  } tga_res_t;

  typedef struct packed {
    logic               start;
    logic               kill;
    logic [TOTAL_W-1:0] dividend;
    logic [DIM_W-1:0]   divisor;
  } tga_div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [QUOT_W-1:0]  quot;
    logic [DIM_W-1:0]   rem;
  } tga_div_res_t;

endpackage

FILE: rtl/core/tga_if.sv
// Valid/ready channel interfaces for the TGA decoder: byte input and result output.
// Depends on nothing.
`timescale 1ns / 1ps

interface tga_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface tga_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] seg_row;
  logic [15:0] seg_column;
  logic [7:0]  seg_count;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        has_alpha;
  logic        image_done;

  modport source (output valid, output kind, output seg_row, output seg_column,
                  output seg_count, output red, output green, output blue,
                  output alpha, output image_width, output image_height,
                  output has_alpha, output image_done, input ready);
  modport sink   (input valid, input kind, input seg_row, input seg_column,
                  input seg_count, input red, input green, input blue,
                  input alpha, input image_width, input image_height,
                  input has_alpha, input image_done, output ready);
endinterface

FILE: rtl/core/tga_div.sv
// Iterative divider that turns a run's end column into rows stepped and new column.
// Restoring division, two quotient bits per cycle. Depends on tga_pkg.
`timescale 1ns / 1ps

module tga_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tga_pkg::tga_div_req_t req_i,
  output tga_pkg::tga_div_res_t res_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [tga_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;
  logic [tga_pkg::TOTAL_W-1:0]        rem_q, rem_d;
  logic [tga_pkg::DSR_W-1:0]          dsr_q, dsr_d;
  logic [tga_pkg::QUOT_W-1:0]         quot_q, quot_d;

  logic [tga_pkg::DSR_W-1:0] r0, r1, r2, d1;
  logic                      ge0, ge1;

  always_comb begin
    r0  = tga_pkg::DSR_W'(rem_q);
    ge0 = (r0 >= dsr_q);
    r1  = ge0 ? (r0 - dsr_q) : r0;
    d1  = dsr_q >> 1;
    ge1 = (r1 >= d1);
    r2  = ge1 ? (r1 - d1) : r1;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quot_d = quot_q;
    if (req_i.kill) begin
      busy_d = 1'b0;
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.dividend;
      dsr_d  = {req_i.divisor, {(tga_pkg::QUOT_W-1){1'b0}}};
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = r2[tga_pkg::TOTAL_W-1:0];
      dsr_d  = d1 >> 1;
      quot_d = {quot_q[tga_pkg::QUOT_W-tga_pkg::DIV_BITS-1:0], ge0, ge1};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == tga_pkg::DIV_CNT_W'(tga_pkg::DIV_CYCLES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    quot_q <= quot_d;
  end

  assign res_o.busy = busy_q;
  assign res_o.done = done_q;
  assign res_o.quot = quot_q;
  assign res_o.rem  = rem_q[tga_pkg::DIM_W-1:0];

endmodule

FILE: rtl/core/tga_parse.sv
// TGA header parser and pixel segment builder: parser state and result logic.
// Depends on tga_pkg and assert_macros.svh; hands long runs to tga_div.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tga_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic [7:0]            byte_i,
  input  logic                  first_i,
  output logic                  stall_o,
  output logic                  res_vld_o,
  output tga_pkg::tga_res_t     res_o,
  output tga_pkg::tga_div_req_t div_req_o,
  input  tga_pkg::tga_div_res_t div_res_i
);

  tga_pkg::tga_phase_e phase_q, phase_d, phase_c;
  logic [4:0]                        idx_q, idx_d, idx_c;
  logic [7:0]                        id_skip_q, id_skip_d;
  logic                              is_rle_q, is_rle_d;
  logic                              four_q, four_d;
  logic [tga_pkg::DIM_W-1:0]         width_q, width_d;
  logic [tga_pkg::DIM_W-1:0]         height_q, height_d;
  logic [tga_pkg::CNT_W-1:0]         pkt_left_q, pkt_left_d;
  logic                              pkt_run_q, pkt_run_d;
  logic [1:0]                        cidx_q, cidx_d;
  logic [23:0]                       colour_q, colour_d;
  logic [tga_pkg::DIM_W-1:0]         row_q, row_d;
  logic [tga_pkg::DIM_W-1:0]         col_q, col_d;
  logic                              cmap_bad_q, cmap_bad_d;
  logic [tga_pkg::AREA_W-1:0]        rem_q, rem_d;

  // Shared datapath
  logic [1:0]                        last_idx;
  logic                              seg_need;
  logic                              div_pend;
  logic                              type_bad;
  logic                              depth_bad;
  logic                              empty_img;
  logic [23:0]                       colour_new;
  logic [tga_pkg::CNT_W-1:0]         count_raw;
  logic [tga_pkg::CNT_W-1:0]         count_cap;
  logic                              seg_done;
  logic [tga_pkg::TOTAL_W-1:0]       total, width_ext, over;
  logic                              wrap0, wrap1;
  logic [tga_pkg::AREA_W-1:0]        area, count_ext;

  assign phase_c = first_i ? tga_pkg::PH_HEADER : phase_q;
  assign idx_c   = first_i ? 5'd0 : idx_q;

  always_comb begin
    last_idx   = four_q ? 2'd3 : 2'd2;
    seg_need   = (phase_c == tga_pkg::PH_PIXEL) && (cidx_q == last_idx);
    div_pend   = div_res_i.busy || div_res_i.done;
    type_bad   = (byte_i != tga_pkg::TYPE_RAW) && (byte_i != tga_pkg::TYPE_RLE);
    depth_bad  = (byte_i != tga_pkg::DEPTH_24) && (byte_i != tga_pkg::DEPTH_32);
    empty_img  = (width_q == '0) || (height_q == '0);
    area       = width_q * height_q;

    colour_new = colour_q;
    case (cidx_q)
      2'd0:    colour_new[7:0]   = byte_i;
      2'd1:    colour_new[15:8]  = byte_i;
      2'd2:    colour_new[23:16] = byte_i;
      default: colour_new        = colour_q;
    endcase

    count_raw = (is_rle_q && pkt_run_q) ? pkt_left_q : tga_pkg::CNT_W'(1);
    if (count_raw == '0) begin
      count_raw = tga_pkg::CNT_W'(1);
    end
    count_ext = tga_pkg::AREA_W'(count_raw);
    seg_done  = (count_ext >= rem_q);
    count_cap = seg_done ? rem_q[tga_pkg::CNT_W-1:0] : count_raw;

    // Column update: up to one row crossing is handled here, more goes to the divider
    total     = tga_pkg::TOTAL_W'(col_q) + tga_pkg::TOTAL_W'(count_raw);
    width_ext = tga_pkg::TOTAL_W'(width_q);
    over      = total - width_ext;
    wrap0     = (total < width_ext);
    wrap1     = (over < width_ext);
  end

  // Hold the segment while the divider still owes the previous run's position
  assign stall_o = seg_need && div_pend;

  // Next state
  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    id_skip_d  = id_skip_q;
    is_rle_d   = is_rle_q;
    four_d     = four_q;
    width_d    = width_q;
    height_d   = height_q;
    pkt_left_d = pkt_left_q;
    pkt_run_d  = pkt_run_q;
    cidx_d     = cidx_q;
    colour_d   = colour_q;
    row_d      = row_q;
    col_d      = col_q;
    cmap_bad_d = cmap_bad_q;
    rem_d      = rem_q;
    div_req_o.start    = 1'b0;
    div_req_o.kill     = adv_i && first_i;
    div_req_o.dividend = total;
    div_req_o.divisor  = width_q;

    if (div_res_i.done) begin
      row_d = row_q - tga_pkg::DIM_W'(div_res_i.quot);
      col_d = div_res_i.rem;
    end

    if (adv_i) begin
      if (first_i) begin
        phase_d    = tga_pkg::PH_HEADER;
        idx_d      = '0;
        id_skip_d  = '0;
        is_rle_d   = 1'b0;
        four_d     = 1'b0;
        width_d    = '0;
        height_d   = '0;
        pkt_left_d = '0;
        pkt_run_d  = 1'b0;
        cidx_d     = '0;
        colour_d   = '0;
        row_d      = '0;
        col_d      = '0;
        cmap_bad_d = 1'b0;
        rem_d      = '0;
      end

      unique case (phase_c)
        tga_pkg::PH_HEADER: begin
          idx_d = idx_c + 5'd1;
          unique case (idx_c)
            tga_pkg::HDR_ID_LEN:    id_skip_d  = byte_i;
            tga_pkg::HDR_CMAP_TYPE: cmap_bad_d = (byte_i != '0);
            tga_pkg::HDR_IMG_TYPE: begin
              if (type_bad) begin
                phase_d = tga_pkg::PH_IDLE;
              end else begin
                is_rle_d = (byte_i == tga_pkg::TYPE_RLE);
                if (cmap_bad_q) begin
                  phase_d = tga_pkg::PH_IDLE;
                end
              end
            end
            tga_pkg::HDR_WIDTH_LO:  width_d  = {8'd0, byte_i};
            tga_pkg::HDR_WIDTH_HI:  width_d  = {byte_i, width_q[7:0]};
            tga_pkg::HDR_HEIGHT_LO: height_d = {8'd0, byte_i};
            tga_pkg::HDR_HEIGHT_HI: height_d = {byte_i, height_q[7:0]};
            tga_pkg::HDR_DEPTH: begin
              if (depth_bad) begin
                phase_d = tga_pkg::PH_IDLE;
              end else begin
                four_d = (byte_i == tga_pkg::DEPTH_32);
              end
            end
            tga_pkg::HDR_DESC: begin
              row_d = height_q - tga_pkg::DIM_W'(1);
              col_d = '0;
              rem_d = area;
              if (empty_img) begin
                phase_d = tga_pkg::PH_IDLE;
              end else if (id_skip_q != '0) begin
                phase_d = tga_pkg::PH_IDSKIP;
              end else begin
                cidx_d  = '0;
                phase_d = is_rle_q ? tga_pkg::PH_PKTHDR : tga_pkg::PH_PIXEL;
              end
            end
            default: ;
          endcase
        end

        tga_pkg::PH_IDSKIP: begin
          id_skip_d = id_skip_q - 8'd1;
          if (id_skip_q == 8'd1) begin
            cidx_d  = '0;
            phase_d = is_rle_q ? tga_pkg::PH_PKTHDR : tga_pkg::PH_PIXEL;
          end
        end

        tga_pkg::PH_PKTHDR: begin
          pkt_left_d = {1'b0, byte_i[6:0] & tga_pkg::PKT_LEN_MASK} + 8'd1;
          pkt_run_d  = byte_i[tga_pkg::PKT_RUN_BIT];
          cidx_d     = '0;
          phase_d    = tga_pkg::PH_PIXEL;
        end

        tga_pkg::PH_PIXEL: begin
          colour_d = colour_new;
          if (cidx_q != last_idx) begin
            cidx_d = cidx_q + 2'd1;
          end else begin
            cidx_d = '0;
            if (width_q == '0) begin
              phase_d = tga_pkg::PH_IDLE;
            end else if (seg_done) begin
              phase_d = tga_pkg::PH_IDLE;
            end else begin
              rem_d = rem_q - count_ext;
              if (wrap0) begin
                col_d = total[tga_pkg::DIM_W-1:0];
              end else if (wrap1) begin
                col_d = over[tga_pkg::DIM_W-1:0];
                row_d = row_q - tga_pkg::DIM_W'(1);
              end else begin
                div_req_o.start = 1'b1;
              end
              if (is_rle_q) begin
                if (pkt_run_q) begin
                  phase_d = tga_pkg::PH_PKTHDR;
                end else begin
                  pkt_left_d = pkt_left_q - 8'd1;
                  if (pkt_left_q == 8'd1) begin
                    phase_d = tga_pkg::PH_PKTHDR;
                  end
                end
              end
            end
          end
        end

        default: ;
      endcase
    end
  end

  // Result
  always_comb begin
    res_vld_o = 1'b0;
    res_o     = '0;
    unique case (phase_c)
      tga_pkg::PH_HEADER: begin
        if (idx_c == tga_pkg::HDR_IMG_TYPE) begin
          if (type_bad) begin
            res_vld_o        = 1'b1;
            res_o.kind       = tga_pkg::KIND_BAD_TYPE;
            res_o.image_done = 1'b1;
          end else if (cmap_bad_q) begin
            res_vld_o        = 1'b1;
            res_o.kind       = tga_pkg::KIND_BAD_FMT;
            res_o.image_done = 1'b1;
          end
        end else if (idx_c == tga_pkg::HDR_DEPTH) begin
          if (depth_bad) begin
            res_vld_o        = 1'b1;
            res_o.kind       = tga_pkg::KIND_BAD_FMT;
            res_o.image_done = 1'b1;
          end
        end else if (idx_c == tga_pkg::HDR_DESC) begin
          res_vld_o          = 1'b1;
          res_o.kind         = tga_pkg::KIND_HDR;
          res_o.image_width  = width_q;
          res_o.image_height = height_q;
          res_o.has_alpha    = four_q;
          res_o.image_done   = empty_img;
        end
      end
      tga_pkg::PH_PIXEL: begin
        if (seg_need && (width_q != '0)) begin
          res_vld_o        = 1'b1;
          res_o.kind       = tga_pkg::KIND_SEG;
          res_o.seg_row    = row_q;
          res_o.seg_column = col_q;
          res_o.seg_count  = count_cap;
          res_o.red        = colour_new[23:16];
          res_o.green      = colour_new[15:8];
          res_o.blue       = colour_new[7:0];
          res_o.alpha      = four_q ? byte_i : tga_pkg::ALPHA_OPAQUE;
          res_o.has_alpha  = four_q;
          res_o.image_done = seg_done;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= tga_pkg::PH_HEADER;
      idx_q      <= '0;
      id_skip_q  <= '0;
      is_rle_q   <= 1'b0;
      four_q     <= 1'b0;
      width_q    <= '0;
      height_q   <= '0;
      pkt_left_q <= '0;
      pkt_run_q  <= 1'b0;
      cidx_q     <= '0;
      colour_q   <= '0;
      row_q      <= '0;
      col_q      <= '0;
      cmap_bad_q <= 1'b0;
      rem_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      id_skip_q  <= id_skip_d;
      is_rle_q   <= is_rle_d;
      four_q     <= four_d;
      width_q    <= width_d;
      height_q   <= height_d;
      pkt_left_q <= pkt_left_d;
      pkt_run_q  <= pkt_run_d;
      cidx_q     <= cidx_d;
      colour_q   <= colour_d;
      row_q      <= row_d;
      col_q      <= col_d;
      cmap_bad_q <= cmap_bad_d;
      rem_q      <= rem_d;
    end
  end

  `TGA_ASSERT(a_div_start_idle, clk_i, rst_ni, div_req_o.start |-> !div_pend, "divider restarted while busy")
  `TGA_ASSERT(a_pixel_width, clk_i, rst_ni, (phase_q == tga_pkg::PH_PIXEL) |-> (width_q != '0), "pixel phase with zero width")
  `TGA_ASSERT(a_pixels_left, clk_i, rst_ni, (phase_q == tga_pkg::PH_PIXEL || phase_q == tga_pkg::PH_PKTHDR) |-> (rem_q != '0), "pixel data phase with no pixels left")
  `TGA_ASSERT(a_col_range, clk_i, rst_ni, (phase_q == tga_pkg::PH_PIXEL && !div_pend) |-> (col_q < width_q), "column beyond image width")

endmodule

FILE: rtl/core/tga_rle_image_decoder_top.sv
// Top level of the TGA RLE image decoder: input register, result register,
// parser and row divider. Depends on tga_pkg, tga_if, tga_parse and tga_div.
//
//   port    dir  handshake     carries
//   in_i    in   valid/ready   data_byte, first_byte
//   out_o   out  valid/ready   kind, segment position/count, RGBA, header info
//
// One file byte is taken per cycle unless the parser stalls or the byte's result
// meets a full result register with out_o.ready low; results leave from that register.
// A run that crosses more than one row boundary starts the row divider;
// the next pixel segment waits until the divider has delivered the new position.
// Reset clears all parser state at once; the first byte after reset is header byte 0.
// A full result register with out_o.ready low holds only bytes that make a result.
`timescale 1ns / 1ps

module tga_rle_image_decoder_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  tga_in_if.sink         in_i,
  tga_out_if.source      out_o
);

  logic                  in_vld_q, in_vld_d;
  logic [7:0]            in_byte_q;
  logic                  in_first_q;
  logic                  out_vld_q, out_vld_d;
  tga_pkg::tga_res_t     out_q;

  logic                  adv;
  logic                  stall;
  logic                  res_vld;
  tga_pkg::tga_res_t     res;
  tga_pkg::tga_div_req_t div_req;
  tga_pkg::tga_div_res_t div_res;

  // Advance the registered byte unless the parser stalls or its result has nowhere to go
  assign adv = in_vld_q && !stall && (!res_vld || !out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_i.valid && in_i.ready) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv && res_vld) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q  <= in_i.data_byte;
      in_first_q <= in_i.first_byte;
    end
    if (adv && res_vld) begin
      out_q <= res;
    end
  end

  tga_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .byte_i    (in_byte_q),
    .first_i   (in_first_q),
    .stall_o   (stall),
    .res_vld_o (res_vld),
    .res_o     (res),
    .div_req_o (div_req),
    .div_res_i (div_res)
  );

  tga_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  assign out_o.valid        = out_vld_q;
  assign out_o.kind         = out_q.kind;
  assign out_o.seg_row      = out_q.seg_row;
  assign out_o.seg_column   = out_q.seg_column;
  assign out_o.seg_count    = out_q.seg_count;
  assign out_o.red          = out_q.red;
  assign out_o.green        = out_q.green;
  assign out_o.blue         = out_q.blue;
  assign out_o.alpha        = out_q.alpha;
  assign out_o.image_width  = out_q.image_width;
  assign out_o.image_height = out_q.image_height;
  assign out_o.has_alpha    = out_q.has_alpha;
  assign out_o.image_done   = out_q.image_done;

endmodule
